### hdl/mbrot_pkg.sv
// Shared constants and types for the Mandelbrot escape-time block.
`default_nettype none
package mbrot_pkg;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int THRESH_BITS   = 31;
  localparam int ITER_BITS     = 15;
  localparam int COUNT_BITS    = 8;
  localparam int Z_BITS        = 32;
  localparam int PROD_BITS     = 2 * Z_BITS;
  localparam int SUM_BITS      = PROD_BITS + 1;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = 2;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_RE_MIN  = 3'd0;
  localparam cfg_idx_t CFG_IM_MIN  = 3'd1;
  localparam cfg_idx_t CFG_RE_STEP = 3'd2;
  localparam cfg_idx_t CFG_IM_STEP = 3'd3;
  localparam cfg_idx_t CFG_THRESH  = 3'd4;
  localparam cfg_idx_t CFG_MAX_IT  = 3'd5;

  localparam logic [31:0]            RST_MIN    = 32'hE000_0000;
  localparam logic [31:0]            RST_STEP   = 32'h0010_0000;
  localparam logic [THRESH_BITS-1:0] RST_THRESH = 31'h4000_0000;
  localparam logic [ITER_BITS-1:0]   RST_MAX_IT = 15'd255;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

### hdl/mbrot_front.sv
// Front end: takes pixel beats and forms the complex point c.
`default_nettype none
module mbrot_front #(
  parameter int COORD_BITS = 32,
  parameter int PIXEL_BITS = 12,
  parameter int CW         = 45
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [PIXEL_BITS-1:0]        in_pixel_x,
  input  wire logic [PIXEL_BITS-1:0]        in_pixel_y,
  input  wire logic signed [COORD_BITS-1:0] re_min,
  input  wire logic signed [COORD_BITS-1:0] im_min,
  input  wire logic signed [COORD_BITS-1:0] re_step,
  input  wire logic signed [COORD_BITS-1:0] im_step,
  input  wire mbrot_pkg::fifo_stat_t        fifo_stat,
  output logic                              push,
  output logic [2*CW-1:0]                   push_data
);
  import mbrot_pkg::*;

  logic                  s_valid_r;
  logic [PIXEL_BITS-1:0] px_r;
  logic [PIXEL_BITS-1:0] py_r;
  logic                  accept;
  logic signed [CW-1:0]  prod_re;
  logic signed [CW-1:0]  prod_im;
  logic signed [CW-1:0]  c_re;
  logic signed [CW-1:0]  c_im;

  assign in_stall = s_valid_r & fifo_stat.full;
  assign accept   = in_valid & ~in_stall;
  assign push     = s_valid_r & ~fifo_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (accept) begin
      s_valid_r <= 1'b1;
    end else if (push) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
    end
  end

  always_comb begin
    prod_re   = CW'($signed({1'b0, px_r})) * CW'(re_step);
    prod_im   = CW'($signed({1'b0, py_r})) * CW'(im_step);
    c_re      = prod_re + CW'(re_min);
    c_im      = prod_im + CW'(im_min);
    push_data = {c_im, c_re};
  end

endmodule
`default_nettype wire

### hdl/mbrot_fifo.sv
// Short queue of formed points between the front end and the iterator.
`default_nettype none
module mbrot_fifo #(
  parameter int WIDTH = 90
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire logic [WIDTH-1:0]      push_data,
  input  wire logic                  pop,
  output logic [WIDTH-1:0]           pop_data,
  output mbrot_pkg::fifo_stat_t      stat
);
  import mbrot_pkg::*;

  logic [WIDTH-1:0]   mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;

  assign stat.full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hdl/mbrot_back.sv
// Iterator: runs z = z^2 + c per point and drives the result register.
`default_nettype none
module mbrot_back #(
  parameter int FRAC_BITS = 28,
  parameter int CW        = 45
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire mbrot_pkg::fifo_stat_t                 fifo_stat,
  input  wire logic [2*CW-1:0]                       pop_data,
  output logic                                       pop,
  input  wire logic [mbrot_pkg::THRESH_BITS-1:0]     escape_threshold,
  input  wire logic [mbrot_pkg::ITER_BITS-1:0]       max_iters,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [mbrot_pkg::COUNT_BITS-1:0]           out_iter_count
);
  import mbrot_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]                  state_r;
  logic [2:0]                  state_nxt;
  logic signed [CW-1:0]        c_re_r;
  logic signed [CW-1:0]        c_im_r;
  logic signed [PROD_BITS-1:0] diff_re_r;
  logic signed [PROD_BITS-1:0] diff_im_r;
  logic signed [PROD_BITS-1:0] sq_re_r;
  logic signed [PROD_BITS-1:0] sq_im_r;
  logic signed [PROD_BITS-1:0] prod_ri_r;
  logic signed [Z_BITS-1:0]    zr_r;
  logic signed [Z_BITS-1:0]    zi_r;
  logic [ITER_BITS-1:0]        iter_r;
  logic                        out_valid_r;
  logic [COUNT_BITS-1:0]       out_count_r;

  logic signed [PROD_BITS-1:0] sh_re;
  logic signed [PROD_BITS-1:0] sh_im;
  logic signed [SUM_BITS-1:0]  t_re;
  logic signed [SUM_BITS-1:0]  t_im;
  logic                        in_rng;
  logic                        at_limit;
  logic [SUM_BITS-1:0]         mag_sum;
  logic [SUM_BITS-1:0]         mag_q;
  logic                        escaped;
  logic [COUNT_BITS-1:0]       count_sat;
  logic                        out_free;

  function automatic logic fits_z(input logic [SUM_BITS-1:0] t);
    logic [SUM_BITS-Z_BITS:0] hi;
    hi = t[SUM_BITS-1:Z_BITS-1];
    return (hi == '0) || ((&hi) && (|t[Z_BITS-2:0]));
  endfunction

  always_comb begin
    sh_re     = diff_re_r >>> FRAC_BITS;
    sh_im     = diff_im_r >>> (FRAC_BITS - 1);
    t_re      = SUM_BITS'(c_re_r) + {sh_re[PROD_BITS-1], sh_re};
    t_im      = SUM_BITS'(c_im_r) + {sh_im[PROD_BITS-1], sh_im};
    in_rng    = fits_z(t_re) & fits_z(t_im);
    at_limit  = (iter_r == max_iters);
    mag_sum   = {1'b0, sq_re_r} + {1'b0, sq_im_r};
    mag_q     = mag_sum >> FRAC_BITS;
    escaped   = (mag_q > SUM_BITS'(escape_threshold));
    count_sat = (|iter_r[ITER_BITS-1:COUNT_BITS]) ? '1 : iter_r[COUNT_BITS-1:0];
    out_free  = ~out_valid_r | ~out_stall;
    pop       = (state_r == ST_IDLE) & ~fifo_stat.empty;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!fifo_stat.empty) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (at_limit || !in_rng) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (escaped) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_ADD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        c_re_r    <= pop_data[CW-1:0];
        c_im_r    <= pop_data[2*CW-1:CW];
        diff_re_r <= '0;
        diff_im_r <= '0;
        iter_r    <= '0;
      end
      ST_ADD: begin
        zr_r <= t_re[Z_BITS-1:0];
        zi_r <= t_im[Z_BITS-1:0];
      end
      ST_MUL: begin
        sq_re_r   <= PROD_BITS'(zr_r) * PROD_BITS'(zr_r);
        sq_im_r   <= PROD_BITS'(zi_r) * PROD_BITS'(zi_r);
        prod_ri_r <= PROD_BITS'(zr_r) * PROD_BITS'(zi_r);
      end
      ST_CHK: begin
        if (!escaped) begin
          iter_r    <= iter_r + ITER_BITS'(1);
          diff_re_r <= sq_re_r - sq_im_r;
          diff_im_r <= prod_ri_r;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_count_r <= count_sat;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_iter_count = out_count_r;

endmodule
`default_nettype wire

### hdl/mandelbrot_escape_time_top.sv
// Mandelbrot escape-time counter: pixel in, saturated iteration count out.
//
// Input channel: in_valid/in_stall with in_pixel_x/in_pixel_y; one beat per pixel.
// Output channel: out_valid/out_stall with out_iter_count; one beat per pixel, in
// input order. Config channel: cfg_valid/cfg_ready (ready always high), cfg_index
// selects re_min, im_min, re_step, im_step, escape_threshold, max_iters; write only
// while no pixel is in flight. Unknown indexes are ignored.
// The front end registers a beat and forms c with one multiply per axis, then
// pushes it into a 4-entry queue, so several pixels can be accepted while the
// iterator is busy. Each iteration steps through add, multiply and magnitude check.
// A pixel stops at the iteration limit or on a large component in the add step,
// or when its magnitude crosses the bound in the check. The single iterator loop
// works on one pixel at a time, so it sets the throughput.
// A stalled result stays in the output register; the iterator holds its next
// finished result until that register frees, and the queue then fills and stalls
// the input side. Reset (rst_n low, synchronous) empties the queue and the output
// and restores the default view: -2.0..-2.0 origin, 1/256 step, bound 4.0, 255
// iterations.
`default_nettype none
module mandelbrot_escape_time_top #(
  parameter int FRAC_BITS  = 28,
  parameter int COORD_BITS = 32,
  parameter int PIXEL_BITS = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [PIXEL_BITS-1:0]                in_pixel_x,
  input  wire logic [PIXEL_BITS-1:0]                in_pixel_y,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [mbrot_pkg::COUNT_BITS-1:0]          out_iter_count,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire mbrot_pkg::cfg_idx_t                  cfg_index,
  input  wire logic [mbrot_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mbrot_pkg::*;

  localparam int CW = COORD_BITS + PIXEL_BITS + 1;

  logic signed [COORD_BITS-1:0] re_min_r;
  logic signed [COORD_BITS-1:0] im_min_r;
  logic signed [COORD_BITS-1:0] re_step_r;
  logic signed [COORD_BITS-1:0] im_step_r;
  logic [THRESH_BITS-1:0]       thresh_r;
  logic [ITER_BITS-1:0]         max_iters_r;
  logic                         cfg_wr;

  fifo_stat_t                   fifo_stat;
  logic                         push;
  logic [2*CW-1:0]              push_data;
  logic                         pop;
  logic [2*CW-1:0]              pop_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_min_r    <= RST_MIN[COORD_BITS-1:0];
      im_min_r    <= RST_MIN[COORD_BITS-1:0];
      re_step_r   <= RST_STEP[COORD_BITS-1:0];
      im_step_r   <= RST_STEP[COORD_BITS-1:0];
      thresh_r    <= RST_THRESH;
      max_iters_r <= RST_MAX_IT;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_RE_MIN:  re_min_r    <= cfg_data[COORD_BITS-1:0];
        CFG_IM_MIN:  im_min_r    <= cfg_data[COORD_BITS-1:0];
        CFG_RE_STEP: re_step_r   <= cfg_data[COORD_BITS-1:0];
        CFG_IM_STEP: im_step_r   <= cfg_data[COORD_BITS-1:0];
        CFG_THRESH:  thresh_r    <= cfg_data[THRESH_BITS-1:0];
        CFG_MAX_IT:  max_iters_r <= cfg_data[ITER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  mbrot_front #(
    .COORD_BITS (COORD_BITS),
    .PIXEL_BITS (PIXEL_BITS),
    .CW         (CW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .re_min     (re_min_r),
    .im_min     (im_min_r),
    .re_step    (re_step_r),
    .im_step    (im_step_r),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_data  (push_data)
  );

  mbrot_fifo #(
    .WIDTH (2*CW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  mbrot_back #(
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fifo_stat        (fifo_stat),
    .pop_data         (pop_data),
    .pop              (pop),
    .escape_threshold (thresh_r),
    .max_iters        (max_iters_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_iter_count   (out_iter_count)
  );

endmodule
`default_nettype wire
